// ===== hw/rtl/rpgm_pkg.sv =====
// Shared types and codes for the radial piecewise gradient map.
`default_nettype none
package rpgm_pkg;

    localparam int unsigned SQRT_BITS = 32;
    localparam int unsigned QUO_BITS  = 32;

    localparam logic [1:0] SEL_LERP = 2'd0;
    localparam logic [1:0] SEL_RIM  = 2'd1;
    localparam logic [1:0] SEL_WALL = 2'd2;

    typedef struct packed {
        logic [31:0] start;
        logic        neg;
        logic [1:0]  sel;
        logic [31:0] rd;
    } t_side;

endpackage
`default_nettype wire

// ===== hw/rtl/rpgm_sqrt_cell.sv =====
// One result bit of the pipelined restoring square root.
`default_nettype none
module rpgm_sqrt_cell #(
    parameter int unsigned BIT = 0
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_vld,
    input  wire logic [63:0] i_rem,
    input  wire logic [31:0] i_root,
    output logic             o_vld,
    output logic [63:0]      o_rem,
    output logic [31:0]      o_root
);

    logic [63:0] w_trial;
    logic [63:0] n_rem;
    logic [31:0] n_root;
    logic        r_vld;
    logic [63:0] r_rem;
    logic [31:0] r_root;

    always_comb begin
        w_trial = ({32'd0, i_root} << (BIT + 1)) | (64'd1 << (2 * BIT));
        n_rem   = i_rem;
        n_root  = i_root;
        if (i_rem >= w_trial) begin
            n_rem       = i_rem - w_trial;
            n_root[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule
`default_nettype wire

// ===== hw/rtl/rpgm_div_cell.sv =====
// One quotient bit of the pipelined restoring divider.
`default_nettype none
module rpgm_div_cell #(
    parameter int unsigned BIT = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_vld,
    input  wire logic [63:0]     i_rem,
    input  wire logic [31:0]     i_span,
    input  wire logic [31:0]     i_quo,
    input  wire rpgm_pkg::t_side i_side,
    output logic                 o_vld,
    output logic [63:0]          o_rem,
    output logic [31:0]          o_span,
    output logic [31:0]          o_quo,
    output rpgm_pkg::t_side      o_side
);

    logic [63:0]     w_sub;
    logic [63:0]     n_rem;
    logic [31:0]     n_quo;
    logic            r_vld;
    logic [63:0]     r_rem;
    logic [31:0]     r_span;
    logic [31:0]     r_quo;
    rpgm_pkg::t_side r_side;

    always_comb begin
        w_sub = {32'd0, i_span} << BIT;
        n_rem = i_rem;
        n_quo = i_quo;
        if (i_rem >= w_sub) begin
            n_rem      = i_rem - w_sub;
            n_quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_span <= i_span;
            r_quo  <= n_quo;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_span = r_span;
    assign o_quo  = r_quo;
    assign o_side = r_side;

endmodule
`default_nettype wire

// ===== hw/rtl/radial_piecewise_gradient_map.sv =====
// Top level of the radial piecewise gradient map.
// Accepts one point per cycle while the output side does not stall, and returns one
// result per point, in order. The pipeline holds a 32-cell square-root chain and a
// 32-cell divider chain, one bit per cell. A stall at the output freezes the whole
// pipeline. Configuration must stay stable while points are in flight.
`default_nettype none
module radial_piecewise_gradient_map (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [30:0] i_pos_x,
    input  wire logic [30:0] i_pos_y,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_level,
    output logic             o_outside_wall,
    output logic [31:0]      o_ring_distance
);

    localparam logic [2:0] REG_CX     = 3'd0;
    localparam logic [2:0] REG_CY     = 3'd1;
    localparam logic [2:0] REG_DIAM   = 3'd2;
    localparam logic [2:0] REG_RING   = 3'd3;
    localparam logic [2:0] REG_CENTER = 3'd4;
    localparam logic [2:0] REG_RINGLV = 3'd5;
    localparam logic [2:0] REG_RIM    = 3'd6;
    localparam logic [2:0] REG_WALL   = 3'd7;
    localparam int unsigned NS = rpgm_pkg::SQRT_BITS;
    localparam int unsigned ND = rpgm_pkg::QUO_BITS;

    logic [30:0] r_cx, r_cy, r_diam, r_ring;
    logic [31:0] r_center_level, r_ring_level, r_rim_level, r_wall_level;

    logic w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0; r_cy <= '0; r_diam <= '0; r_ring <= '0;
            r_center_level <= '0; r_ring_level <= '0;
            r_rim_level <= '0; r_wall_level <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CX:     r_cx <= i_cfg_data[30:0];
                REG_CY:     r_cy <= i_cfg_data[30:0];
                REG_DIAM:   r_diam <= i_cfg_data[30:0];
                REG_RING:   r_ring <= i_cfg_data[30:0];
                REG_CENTER: r_center_level <= i_cfg_data;
                REG_RINGLV: r_ring_level <= i_cfg_data;
                REG_RIM:    r_rim_level <= i_cfg_data;
                REG_WALL:   r_wall_level <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: absolute offsets from the center
    logic [31:0] w_dx, w_dy, n_ax, n_ay;
    logic        r_s0_vld;
    logic [31:0] r_s0_ax, r_s0_ay;

    always_comb begin
        w_dx = {i_pos_x[30], i_pos_x} - {r_cx[30], r_cx};
        w_dy = {i_pos_y[30], i_pos_y} - {r_cy[30], r_cy};
        n_ax = w_dx[31] ? (32'd0 - w_dx) : w_dx;
        n_ay = w_dy[31] ? (32'd0 - w_dy) : w_dy;
    end

    // stage 1: squares; stage 2: sum
    logic        r_s1_vld, r_s2_vld;
    logic [63:0] r_s1_sx, r_s1_sy, r_s2_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (w_adv) begin
            r_s0_vld <= i_valid;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_ax  <= n_ax;
            r_s0_ay  <= n_ay;
            r_s1_sx  <= r_s0_ax * r_s0_ax;
            r_s1_sy  <= r_s0_ay * r_s0_ay;
            r_s2_sum <= r_s1_sx + r_s1_sy;
        end
    end

    // square-root chain
    logic        w_sq_vld  [0:NS];
    logic [63:0] w_sq_rem  [0:NS];
    logic [31:0] w_sq_root [0:NS];

    assign w_sq_vld[0]  = r_s2_vld;
    assign w_sq_rem[0]  = r_s2_sum;
    assign w_sq_root[0] = '0;

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        rpgm_sqrt_cell #(.BIT(NS - 1 - k)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_adv),
            .i_vld  (w_sq_vld[k]),
            .i_rem  (w_sq_rem[k]),
            .i_root (w_sq_root[k]),
            .o_vld  (w_sq_vld[k+1]),
            .o_rem  (w_sq_rem[k+1]),
            .o_root (w_sq_root[k+1])
        );
    end

    // stage 3: segment choice
    logic [31:0]     w_r, w_outer, w_ringr;
    logic [31:0]     n_start, n_end, n_offset, n_span, n_mag;
    logic [32:0]     w_delta;
    rpgm_pkg::t_side n_side;
    logic            r_s3_vld, r_s4_vld;
    logic [31:0]     r_s3_mag, r_s3_offset, r_s3_span, r_s4_span;
    rpgm_pkg::t_side r_s3_side, r_s4_side;
    logic [63:0]     r_s4_prod;

    always_comb begin
        w_r      = w_sq_root[NS];
        w_outer  = {2'b00, r_diam[30:1]};
        w_ringr  = {1'b0, r_ring};
        n_start  = r_ring_level;
        n_end    = r_rim_level;
        n_offset = w_r - w_ringr;
        n_span   = w_outer - w_ringr;
        n_side.sel = rpgm_pkg::SEL_LERP;
        if (w_r >= w_ringr && w_r <= w_outer) begin
            if (w_outer == w_ringr) begin
                n_side.sel = rpgm_pkg::SEL_RIM;
            end
        end else if (w_r < w_ringr) begin
            n_start  = r_center_level;
            n_end    = r_ring_level;
            n_offset = w_r;
            n_span   = w_ringr;
        end else begin
            n_side.sel = rpgm_pkg::SEL_WALL;
        end
        w_delta      = {n_end[31], n_end} - {n_start[31], n_start};
        n_side.neg   = w_delta[32];
        n_mag        = w_delta[32] ? (32'd0 - w_delta[31:0]) : w_delta[31:0];
        n_side.start = n_start;
        n_side.rd    = (w_r > w_ringr) ? (w_r - w_ringr) : (w_ringr - w_r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else if (w_adv) begin
            r_s3_vld <= w_sq_vld[NS];
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_mag    <= n_mag;
            r_s3_offset <= n_offset;
            r_s3_span   <= n_span;
            r_s3_side   <= n_side;
            r_s4_prod   <= r_s3_mag * r_s3_offset;
            r_s4_span   <= r_s3_span;
            r_s4_side   <= r_s3_side;
        end
    end

    // divider chain
    logic            w_dv_vld  [0:ND];
    logic [63:0]     w_dv_rem  [0:ND];
    logic [31:0]     w_dv_span [0:ND];
    logic [31:0]     w_dv_quo  [0:ND];
    rpgm_pkg::t_side w_dv_side [0:ND];

    assign w_dv_vld[0]  = r_s4_vld;
    assign w_dv_rem[0]  = r_s4_prod;
    assign w_dv_span[0] = r_s4_span;
    assign w_dv_quo[0]  = '0;
    assign w_dv_side[0] = r_s4_side;

    for (genvar k = 0; k < ND; k++) begin : g_div
        rpgm_div_cell #(.BIT(ND - 1 - k)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_adv),
            .i_vld  (w_dv_vld[k]),
            .i_rem  (w_dv_rem[k]),
            .i_span (w_dv_span[k]),
            .i_quo  (w_dv_quo[k]),
            .i_side (w_dv_side[k]),
            .o_vld  (w_dv_vld[k+1]),
            .o_rem  (w_dv_rem[k+1]),
            .o_span (w_dv_span[k+1]),
            .o_quo  (w_dv_quo[k+1]),
            .o_side (w_dv_side[k+1])
        );
    end

    // output stage
    rpgm_pkg::t_side w_fs;
    logic [33:0]     w_sum;
    logic [31:0]     n_level;
    logic            r_o_vld;
    logic [31:0]     r_o_level, r_o_rd;
    logic            r_o_wall;

    always_comb begin
        w_fs  = w_dv_side[ND];
        w_sum = w_fs.neg ? ({{2{w_fs.start[31]}}, w_fs.start} - {2'b00, w_dv_quo[ND]})
                         : ({{2{w_fs.start[31]}}, w_fs.start} + {2'b00, w_dv_quo[ND]});
        if (!w_sum[33] && w_sum[32:31] != 2'b00) begin
            n_level = 32'h7FFF_FFFF;
        end else if (w_sum[33] && w_sum[32:31] != 2'b11) begin
            n_level = 32'h8000_0000;
        end else begin
            n_level = w_sum[31:0];
        end
        case (w_fs.sel)
            rpgm_pkg::SEL_RIM:  n_level = r_rim_level;
            rpgm_pkg::SEL_WALL: n_level = r_wall_level;
            default: ;
        endcase
    end

    assign w_adv = !r_o_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_o_vld <= w_dv_vld[ND];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_level <= n_level;
            r_o_rd    <= w_fs.rd;
            r_o_wall  <= (w_fs.sel == rpgm_pkg::SEL_WALL);
        end
    end

    assign o_ready         = w_adv;
    assign o_valid         = r_o_vld;
    assign o_level         = r_o_level;
    assign o_outside_wall  = r_o_wall;
    assign o_ring_distance = r_o_rd;

    a_wall_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_outside_wall) |-> (o_level == r_wall_level))
        else $error("wall result without wall level");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_s0_vld)
        else $error("accepted point lost at entry");

endmodule
`default_nettype wire
